FILE: design/xdcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xdcl_pkg: shared types and codes of the XOR-distance closest list
// Transfer types of both channels, action and status codes, register map.
// ----------------------------------------------------------------------------
package xdcl_pkg;

  // list depth used when the top level is not overridden
  localparam int DEFAULT_LIST_SIZE = 5;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam logic [1:0] REG_TARGET_HIGH   = 2'd0;
  localparam logic [1:0] REG_TARGET_MIDDLE = 2'd1;
  localparam logic [1:0] REG_TARGET_LOW    = 2'd2;

  // input actions
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_OFFER = 2'd1;
  localparam logic [1:0] ACT_DUMP  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_CLEARED   = 3'd3;
  localparam logic [2:0] ST_ENTRY     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] contact_index;
    logic [63:0] id_high;
    logic [63:0] id_middle;
    logic [31:0] id_low;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  position;
    logic [15:0] entry_index;
    logic [63:0] entry_id_high;
    logic [63:0] entry_id_middle;
    logic [31:0] entry_id_low;
    logic        last;
  } out_item_t;

  // one stored contact
  typedef struct packed {
    logic [15:0] contact;
    logic [63:0] id_high;
    logic [63:0] id_middle;
    logic [31:0] id_low;
  } entry_t;

  // list update commands from the controller
  typedef struct packed {
    logic clear;
    logic insert;
  } list_ctl_t;

  // outcome of an offer against the current list
  typedef struct packed {
    logic dup;
    logic reject;
  } offer_res_t;

endpackage : xdcl_pkg
`default_nettype wire

FILE: design/xdcl_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xdcl_list: sorted contact store
// Holds the contacts in ascending XOR distance to the target, checks an
// offer against every slot in parallel and shifts the tail on insertion.
// ----------------------------------------------------------------------------
module xdcl_list #(
  parameter int LIST_SIZE = xdcl_pkg::DEFAULT_LIST_SIZE,
  parameter int IDXW      = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1,
  parameter int CW        = $clog2(LIST_SIZE + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire xdcl_pkg::list_ctl_t  ctl,
  input  wire xdcl_pkg::in_item_t   offer,
  input  wire logic [159:0]         target,
  input  wire logic [IDXW-1:0]      rd_idx,
  output xdcl_pkg::offer_res_t      res,
  output logic [IDXW-1:0]           ins_pos,
  output logic [CW-1:0]             count,
  output xdcl_pkg::entry_t          rd_entry
);

  xdcl_pkg::entry_t slot_r   [LIST_SIZE];
  xdcl_pkg::entry_t slot_nxt [LIST_SIZE];
  xdcl_pkg::entry_t new_entry;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [LIST_SIZE-1:0] valid_vec;
  logic [LIST_SIZE-1:0] dup_vec;
  logic [LIST_SIZE-1:0] closer_vec;
  logic [159:0]         dist_new;
  logic [IDXW-1:0]      first_closer;
  logic                 any_closer;

  assign new_entry = '{contact:   offer.contact_index,
                       id_high:   offer.id_high,
                       id_middle: offer.id_middle,
                       id_low:    offer.id_low};
  assign dist_new  = {offer.id_high, offer.id_middle, offer.id_low} ^ target;

  // per-slot duplicate and distance compare
  always_comb begin
    for (int i = 0; i < LIST_SIZE; i++) begin
      valid_vec[i]  = (CW'(i) < count_r);
      dup_vec[i]    = valid_vec[i] && (slot_r[i].contact == offer.contact_index);
      closer_vec[i] = valid_vec[i] &&
                      (dist_new < ({slot_r[i].id_high, slot_r[i].id_middle,
                                    slot_r[i].id_low} ^ target));
    end
  end

  // first slot that is strictly farther than the offer
  always_comb begin
    first_closer = '0;
    any_closer   = 1'b0;
    for (int i = LIST_SIZE - 1; i >= 0; i--) begin
      if (closer_vec[i]) begin
        first_closer = IDXW'(i);
        any_closer   = 1'b1;
      end
    end
  end

  assign res.dup    = |dup_vec;
  assign res.reject = !any_closer && (count_r == CW'(LIST_SIZE));
  assign ins_pos    = any_closer ? first_closer : count_r[IDXW-1:0];

  // insertion with shift of the tail; last slot drops off when full
  always_comb begin
    for (int j = 0; j < LIST_SIZE; j++) begin
      slot_nxt[j] = slot_r[j];
      if (ctl.insert) begin
        if (IDXW'(j) == ins_pos) begin
          slot_nxt[j] = new_entry;
        end else if (IDXW'(j) > ins_pos) begin
          slot_nxt[j] = slot_r[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.insert && (count_r != CW'(LIST_SIZE))) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LIST_SIZE; j++) begin
      slot_r[j] <= slot_nxt[j];
    end
  end

  assign count    = count_r;
  assign rd_entry = slot_r[rd_idx];

endmodule : xdcl_list
`default_nettype wire

FILE: design/xor_distance_closest_list_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_distance_closest_list_unit: k-closest contact list by XOR distance
// Registers each action, resolves it combinationally against the sorted list
// and presents the results through an output register.
// ----------------------------------------------------------------------------
//  channel  ports                         direction  transfer
//  input    in_valid/in_ready/in_data     in         one action per transfer
//  result   out_valid/out_ready/out_data  out        one result per transfer
//  config   cfg_p* (APB-style, 64 bit)    in/out     target key, 3 registers
//
//  Clear and offer can follow back to back unless the result side stalls;
//  the result register loads with each emitted result. A dump of n entries
//  occupies the action register for n results (one for an empty list), one
//  list read per cycle unless stalled. Reset clears the fill count and the
//  target; slot contents need no clearing pass. Back-pressure on the result
//  side holds the action register, which in turn holds in_ready low.
// ----------------------------------------------------------------------------
module xor_distance_closest_list_unit #(
  parameter int LIST_SIZE = xdcl_pkg::DEFAULT_LIST_SIZE
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire xdcl_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output xdcl_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [xdcl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [xdcl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [xdcl_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int IDXW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int CW   = $clog2(LIST_SIZE + 1);

  // target key registers
  logic [63:0] tgt_high_r;
  logic [63:0] tgt_middle_r;
  logic [31:0] tgt_low_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // action register and result register
  xdcl_pkg::in_item_t  act_r;
  logic                act_vld_r;
  xdcl_pkg::out_item_t out_r;
  logic                out_vld_r;
  xdcl_pkg::out_item_t res;

  // dump walk
  logic [IDXW-1:0] dump_idx_r;
  logic            dump_last;
  logic [31:0]     pos_wide;

  // list interface
  xdcl_pkg::list_ctl_t  ctl;
  xdcl_pkg::offer_res_t ores;
  logic [IDXW-1:0]      ins_pos;
  logic [CW-1:0]        count;
  xdcl_pkg::entry_t     rd_entry;

  logic out_space;
  logic emit;
  logic done;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_high_r   <= '0;
      tgt_middle_r <= '0;
      tgt_low_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        xdcl_pkg::REG_TARGET_HIGH:   tgt_high_r   <= cfg_pwdata;
        xdcl_pkg::REG_TARGET_MIDDLE: tgt_middle_r <= cfg_pwdata;
        xdcl_pkg::REG_TARGET_LOW:    tgt_low_r    <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      xdcl_pkg::REG_TARGET_HIGH:   cfg_prdata = tgt_high_r;
      xdcl_pkg::REG_TARGET_MIDDLE: cfg_prdata = tgt_middle_r;
      xdcl_pkg::REG_TARGET_LOW:    cfg_prdata = {32'd0, tgt_low_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------- sorted list ----------------
  xdcl_list #(
    .LIST_SIZE (LIST_SIZE),
    .IDXW      (IDXW),
    .CW        (CW)
  ) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .offer    (act_r),
    .target   ({tgt_high_r, tgt_middle_r, tgt_low_r}),
    .rd_idx   (dump_idx_r),
    .res      (ores),
    .ins_pos  (ins_pos),
    .count    (count),
    .rd_entry (rd_entry)
  );

  // ---------------- control ----------------
  assign out_space = !out_vld_r || out_ready;
  assign dump_last = (count == '0) || (CW'(dump_idx_r) + CW'(1) == count);

  // unused action code retires without a result
  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    case (act_r.action) inside
      xdcl_pkg::ACT_CLEAR, xdcl_pkg::ACT_OFFER: begin
        emit = act_vld_r && out_space;
        done = emit;
      end
      xdcl_pkg::ACT_DUMP: begin
        emit = act_vld_r && out_space;
        done = emit && dump_last;
      end
      default: begin
        done = act_vld_r;
      end
    endcase
  end

  assign in_ready   = !act_vld_r || done;
  assign ctl.clear  = emit && (act_r.action == xdcl_pkg::ACT_CLEAR);
  assign ctl.insert = emit && (act_r.action == xdcl_pkg::ACT_OFFER) &&
                      !ores.dup && !ores.reject;

  // ---------------- result composition ----------------
  always_comb begin
    res      = '0;
    res.last = 1'b1;
    pos_wide = '0;
    case (act_r.action)
      xdcl_pkg::ACT_CLEAR: begin
        res.status = xdcl_pkg::ST_CLEARED;
      end
      xdcl_pkg::ACT_OFFER: begin
        if (ores.dup) begin
          res.status = xdcl_pkg::ST_DUPLICATE;
        end else if (ores.reject) begin
          res.status = xdcl_pkg::ST_REJECTED;
        end else begin
          pos_wide     = 32'(ins_pos);
          res.status   = xdcl_pkg::ST_INSERTED;
          res.position = pos_wide[2:0];
        end
      end
      xdcl_pkg::ACT_DUMP: begin
        if (count == '0) begin
          res.status = xdcl_pkg::ST_EMPTY;
        end else begin
          pos_wide            = 32'(dump_idx_r);
          res.status          = xdcl_pkg::ST_ENTRY;
          res.position        = pos_wide[2:0];
          res.entry_index     = rd_entry.contact;
          res.entry_id_high   = rd_entry.id_high;
          res.entry_id_middle = rd_entry.id_middle;
          res.entry_id_low    = rd_entry.id_low;
          res.last            = dump_last;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
      dump_idx_r <= '0;
    end else begin
      if (in_ready) begin
        act_vld_r <= in_valid;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (done) begin
        dump_idx_r <= '0;
      end else if (emit && (act_r.action == xdcl_pkg::ACT_DUMP)) begin
        dump_idx_r <= dump_idx_r + IDXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      act_r <= in_data;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule : xor_distance_closest_list_unit
`default_nettype wire
